FILE: hw/rtl/dac_pkg.sv
// ---------------------------------------------------------------------------
// DNA Aho-Corasick package
// Shared request and status codes and the sequencer state type.
// ---------------------------------------------------------------------------
package dac_pkg;

  typedef enum logic [2:0] {
    REQ_CLEAR   = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_BUILD   = 3'd2,
    REQ_SCAN    = 3'd3,
    REQ_RESTART = 3'd4
  } req_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_LOCKED   = 2'd2;
  localparam logic [1:0] ST_NOTBUILT = 2'd3;

  localparam int unsigned ALPHA = 4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,      // write root child rows, one symbol per cycle
    S_INS_RD,   // wait for child read
    S_INS_WR,   // decide and update
    S_INS_INIT, // clear new node's child row
    S_SCAN_RD,  // wait for child read
    S_SCAN_EF,  // wait for end flag read
    S_B_POP,    // read queue head
    S_B_CUR,    // have cur from the queue, read fail[cur]
    S_B_WAIT,   // read child[cur][i] and child[fail[cur]][i]
    S_B_PROC,   // process child
    S_B_EF,     // end_flag[f] read in flight
    S_B_EFWR,   // write end flag of pos
    S_OUT       // result waits for transfer
  } state_e;

endpackage

FILE: hw/rtl/dac_if.sv
// ---------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface dac_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [1:0] symbol;
  logic       last;
  modport source (output valid, req_type, symbol, last, input ready);
  modport sink (input valid, req_type, symbol, last, output ready);
endinterface

interface dac_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] node;
  logic       match;
  modport source (output valid, status, node, match, input ready);
  modport sink (input valid, status, node, match, output ready);
endinterface

FILE: hw/rtl/dac_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hw/rtl/dna_aho_corasick_automaton.sv
// Insert: a child table read, then a decision; when a node is created, its child row is cleared in S_INS_INIT.
// Scan: a child table read followed by a dependent end flag read.
// Restart, unknown and refused requests go straight to the result. Clear: root row one symbol per cycle.
// Build: a breadth-first pass that pops each queued node and processes its children in turn.
// One request at a time; the next is accepted the cycle after the result transfer.
// Reset: asynchronous, active low; root only, not built. Stores undefined until the first clear.
// ---------------------------------------------------------------------------
// DNA Aho-Corasick automaton
// Trie insert, breadth-first link build and scan over memories.
// ---------------------------------------------------------------------------
module dna_aho_corasick_automaton #(
  parameter int unsigned MAX_NODES = 128
) (
  input logic      clk_i,
  input logic      rst_ni,
  dac_req_if.sink  req_i,
  dac_rsp_if.source rsp_o
);
  import dac_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = NW + 1;
  localparam int unsigned AW = NW + 2;

  state_e state_q, state_d;

  logic [NW-1:0] ins_q, ins_d, scan_q, scan_d, cur_q, cur_d, pos_q, pos_d;
  logic [NW-1:0] f_q, f_d, fcur_q, fcur_d;
  logic [CW-1:0] cnt_q, cnt_d, head_q, head_d, tail_q, tail_d;
  logic          built_q, built_d;
  logic [1:0]    sym_q, sym_d, i_q, i_d;
  logic          last_q, last_d;
  logic [1:0]    st_q, st_d;
  logic [NW-1:0] onode_q, onode_d;
  logic          omatch_q, omatch_d;

  // memories
  logic          c_we, f_we, e_we, q_we;
  logic [AW-1:0] c_wa, c_ra, c2_ra;
  logic [NW-1:0] c_wd, c_rd, c2_rd;
  logic [NW-1:0] f_wa, f_wd, f_ra, f_rd;
  logic [NW-1:0] e_wa, e_ra;
  logic          e_wd, e_rd;
  logic [NW-1:0] q_wa, q_wd, q_ra, q_rd;

  // Two child-table copies give two read ports; both take every write.
  dac_ram #(.WIDTH(NW), .DEPTH(ALPHA*MAX_NODES)) u_child (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));
  dac_ram #(.WIDTH(NW), .DEPTH(ALPHA*MAX_NODES)) u_child2 (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c2_ra),
    .rdata_o(c2_rd));
  dac_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd));
  dac_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_end (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd));
  dac_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd));

  logic [NW-1:0] cnt_n;
  assign cnt_n = cnt_q[NW-1:0];

  // next state and datapath
  always_comb begin
    state_d = state_q;
    ins_d = ins_q; scan_d = scan_q; cur_d = cur_q; pos_d = pos_q;
    f_d = f_q; fcur_d = fcur_q;
    cnt_d = cnt_q; head_d = head_q; tail_d = tail_q; built_d = built_q;
    sym_d = sym_q; i_d = i_q; last_d = last_q;
    st_d = st_q; onode_d = onode_q; omatch_d = omatch_q;
    c_we = 1'b0; c_wa = '0; c_wd = '0;
    c_ra = {ins_q, sym_q}; c2_ra = {fcur_q, i_q};
    f_we = 1'b0; f_wa = pos_q; f_wd = f_q; f_ra = cur_q;
    e_we = 1'b0; e_wa = pos_q; e_wd = 1'b0; e_ra = c_rd;
    q_we = 1'b0; q_wa = tail_q[NW-1:0]; q_wd = c_rd; q_ra = head_q[NW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          sym_d = req_i.symbol; last_d = req_i.last;
          st_d = ST_OK; onode_d = '0; omatch_d = 1'b0; i_d = '0;
          case (req_i.req_type)
            REQ_CLEAR: begin
              cnt_d = CW'(1); ins_d = '0; scan_d = '0; built_d = 1'b0;
              state_d = S_CLR;
            end
            REQ_INSERT: begin
              if (built_q) begin
                st_d = ST_LOCKED; onode_d = ins_q; state_d = S_OUT;
              end else begin
                c_ra = {ins_q, req_i.symbol};
                state_d = S_INS_RD;
              end
            end
            REQ_BUILD: begin
              if (built_q) begin
                st_d = ST_LOCKED; state_d = S_OUT;
              end else begin
                q_we = 1'b1; q_wa = '0; q_wd = '0;
                head_d = '0; tail_d = CW'(1);
                state_d = S_B_POP;
              end
            end
            REQ_SCAN: begin
              if (!built_q) begin
                st_d = ST_NOTBUILT; onode_d = scan_q; state_d = S_OUT;
              end else begin
                c_ra = {scan_q, req_i.symbol};
                state_d = S_SCAN_RD;
              end
            end
            REQ_RESTART: begin
              scan_d = '0; state_d = S_OUT;
            end
            default: begin
              onode_d = scan_q; state_d = S_OUT;
            end
          endcase
        end
      end
      S_CLR: begin
        c_we = 1'b1; c_wa = {{NW{1'b0}}, i_q}; c_wd = '0;
        f_we = 1'b1; f_wa = '0; f_wd = '0;
        e_we = 1'b1; e_wa = '0; e_wd = 1'b0;
        i_d = i_q + 2'd1;
        if (i_q == 2'd3) state_d = S_OUT;
      end
      S_INS_RD: state_d = S_INS_WR;
      S_INS_WR: begin
        if (c_rd != '0) begin
          onode_d = c_rd;
          if (last_q) begin
            e_we = 1'b1; e_wa = c_rd; e_wd = 1'b1; ins_d = '0;
          end else ins_d = c_rd;
          state_d = S_OUT;
        end else if (cnt_q >= CW'(MAX_NODES)) begin
          st_d = ST_FULL; onode_d = ins_q;
          if (last_q) ins_d = '0;
          state_d = S_OUT;
        end else begin
          c_we = 1'b1; c_wa = {ins_q, sym_q}; c_wd = cnt_n;
          f_we = 1'b1; f_wa = cnt_n; f_wd = '0;
          e_we = 1'b1; e_wa = cnt_n; e_wd = last_q;
          onode_d = cnt_n; pos_d = cnt_n;
          ins_d = last_q ? '0 : cnt_n;
          cnt_d = cnt_q + CW'(1);
          state_d = S_INS_INIT;
        end
      end
      S_INS_INIT: begin
        c_we = 1'b1; c_wa = {pos_q, i_q}; c_wd = '0;
        i_d = i_q + 2'd1;
        if (i_q == 2'd3) state_d = S_OUT;
      end
      S_SCAN_RD: begin
        scan_d = c_rd; onode_d = c_rd; e_ra = c_rd;
        state_d = S_SCAN_EF;
      end
      S_SCAN_EF: begin
        omatch_d = e_rd; state_d = S_OUT;
      end
      S_B_POP: begin
        if (head_q < tail_q && head_q < CW'(MAX_NODES)) begin
          head_d = head_q + CW'(1);
          i_d = '0;
          state_d = S_B_CUR;
        end else begin
          built_d = 1'b1; state_d = S_OUT;
        end
      end
      S_B_CUR: begin
        // queue data and, in the cycle after, fail[cur]
        cur_d = q_rd; f_ra = q_rd;
        state_d = S_B_WAIT;
        fcur_d = '0;
      end
      S_B_WAIT: begin
        if (cur_q != '0) fcur_d = f_rd;
        c_ra = {cur_q, i_q};
        c2_ra = {(cur_q != '0) ? f_rd : fcur_q, i_q};
        state_d = S_B_PROC;
      end
      S_B_PROC: begin
        // c_rd = child[cur][i], c2_rd = child[fail[cur]][i]
        if (c_rd != '0) begin
          if (tail_q < CW'(MAX_NODES)) begin
            q_we = 1'b1; q_wa = tail_q[NW-1:0]; q_wd = c_rd;
            tail_d = tail_q + CW'(1);
          end
          pos_d = c_rd;
          f_d = (cur_q == '0) ? '0 : c2_rd;
          e_ra = (cur_q == '0) ? '0 : c2_rd;
          state_d = S_B_EF;
        end else begin
          if (cur_q != '0) begin
            c_we = 1'b1; c_wa = {cur_q, i_q}; c_wd = c2_rd;
          end
          i_d = i_q + 2'd1;
          state_d = (i_q == 2'd3) ? S_B_POP : S_B_WAIT;
        end
      end
      S_B_EF: begin
        f_we = 1'b1;
        e_ra = pos_q; f_d = {{(NW-1){1'b0}}, e_rd};
        state_d = S_B_EFWR;
      end
      S_B_EFWR: begin
        e_we = 1'b1; e_wa = pos_q; e_wd = e_rd | f_q[0];
        i_d = i_q + 2'd1;
        state_d = (i_q == 2'd3) ? S_B_POP : S_B_WAIT;
      end
      S_OUT: if (rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ins_q <= '0; scan_q <= '0; cnt_q <= CW'(1); built_q <= 1'b0;
      head_q <= '0; tail_q <= '0;
    end else begin
      state_q <= state_d;
      ins_q <= ins_d; scan_q <= scan_d; cnt_q <= cnt_d; built_q <= built_d;
      head_q <= head_d; tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; pos_q <= pos_d; f_q <= f_d; fcur_q <= fcur_d;
    sym_q <= sym_d; i_q <= i_d; last_q <= last_d;
    st_q <= st_d; onode_q <= onode_d; omatch_q <= omatch_d;
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = (state_q == S_OUT);
  assign rsp_o.status = st_q;
  assign rsp_o.node   = 7'(onode_q);
  assign rsp_o.match  = omatch_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_NODES)) else $error("node count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(st_q))
    else $error("result dropped");
  a_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");
endmodule

FILE: test/dac_aho_checker.sv
// ---------------------------------------------------------------------------
// Aho-Corasick result checker
// Tracks the automaton state from accepted requests, predicts each result and
// compares it field by field with the accepted results, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dac_aho_checker #(
  parameter int unsigned MAX_NODES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dac_req_if.sink     req_mon,
  dac_rsp_if.sink     rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import dac_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] node;
    logic       match;
  } result_t;

  int unsigned goto_tab [ALPHA*MAX_NODES];
  int unsigned fail_tab [MAX_NODES];
  bit          term_tab [MAX_NODES];
  int unsigned order_q  [$];
  int unsigned trie_size;
  int unsigned ins_at;
  int unsigned scan_at;
  bit          is_built;
  result_t     expected_q [$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic void blank_node(int unsigned n);
    for (int i = 0; i < ALPHA; i++) goto_tab[n*ALPHA+i] = 0;
    fail_tab[n] = 0;
    term_tab[n] = 0;
  endfunction

  // Breadth-first pass: fail links, inherited end flags, completed transitions.
  function automatic void link_trie();
    int unsigned cur, pos, f;
    order_q = {};
    order_q.push_back(0);
    while (order_q.size() != 0) begin
      cur = order_q.pop_front();
      for (int i = 0; i < ALPHA; i++) begin
        pos = goto_tab[cur*ALPHA+i];
        if (pos != 0) begin
          order_q.push_back(pos);
          f = (cur == 0) ? 0 : goto_tab[fail_tab[cur]*ALPHA+i];
          fail_tab[pos] = f;
          term_tab[pos] = term_tab[pos] | term_tab[f];
        end else if (cur != 0) begin
          goto_tab[cur*ALPHA+i] = goto_tab[fail_tab[cur]*ALPHA+i];
        end
      end
    end
  endfunction

  function automatic result_t predict_result(logic [2:0] kind, logic [1:0] sym, logic fin);
    result_t r;
    int unsigned nxt;
    r = '0;
    case (kind)
      REQ_CLEAR: begin
        blank_node(0);
        trie_size = 1; ins_at = 0; scan_at = 0; is_built = 0;
      end
      REQ_INSERT: begin
        if (is_built) begin
          r.status = ST_LOCKED; r.node = 7'(ins_at);
        end else begin
          nxt = goto_tab[ins_at*ALPHA+sym];
          if (nxt == 0 && trie_size >= MAX_NODES) begin
            r.status = ST_FULL; r.node = 7'(ins_at);
            if (fin) ins_at = 0;
          end else begin
            if (nxt == 0) begin
              nxt = trie_size;
              blank_node(nxt);
              goto_tab[ins_at*ALPHA+sym] = nxt;
              trie_size++;
            end
            r.node = 7'(nxt);
            if (fin) begin
              term_tab[nxt] = 1; ins_at = 0;
            end else begin
              ins_at = nxt;
            end
          end
        end
      end
      REQ_BUILD: begin
        if (is_built) r.status = ST_LOCKED;
        else begin
          link_trie();
          is_built = 1;
        end
      end
      REQ_SCAN: begin
        if (!is_built) begin
          r.status = ST_NOTBUILT; r.node = 7'(scan_at);
        end else begin
          scan_at = goto_tab[scan_at*ALPHA+sym];
          r.node = 7'(scan_at); r.match = term_tab[scan_at];
        end
      end
      REQ_RESTART: scan_at = 0;
      default: r.node = 7'(scan_at);
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      trie_size = 1; ins_at = 0; scan_at = 0; is_built = 0;
      expected_q = {};
      fails = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          if (rsp_mon.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, rsp_mon.status);
            fails++;
          end
          if (rsp_mon.node !== exp_r.node) begin
            $error("node: expected %0d, actual %0d", exp_r.node, rsp_mon.node);
            fails++;
          end
          if (rsp_mon.match !== exp_r.match) begin
            $error("match: expected %0d, actual %0d", exp_r.match, rsp_mon.match);
            fails++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(predict_result(req_mon.req_type, req_mon.symbol, req_mon.last));
    end
  end

endmodule

FILE: test/tb_dna_aho_corasick_automaton.sv
// ---------------------------------------------------------------------------
// Aho-Corasick automaton testbench
// Drives clear, insert, build, scan and restart sequences with random gaps
// on both channels; a checker module predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dna_aho_corasick_automaton;
  import dac_pkg::*;

  localparam int unsigned NODES     = 128;
  localparam int unsigned CYCLE_CAP = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          long_stall = 0;
  bit          stim_done = 0;

  dac_req_if req_if ();
  dac_rsp_if rsp_if ();

  dna_aho_corasick_automaton #(.MAX_NODES(NODES)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  dac_aho_checker #(.MAX_NODES(NODES)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if.sink),
    .rsp_mon     (rsp_if.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Holds each request until its transfer; inputs change at the falling edge.
  task automatic send_req(logic [2:0] kind, logic [1:0] sym, logic fin);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.symbol   <= sym;
    req_if.last     <= fin;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic insert_pattern(int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_req(REQ_INSERT, 2'($urandom_range(0, 3)), k == len - 1);
  endtask

  // A whole session: clear, patterns, build, then a scanned text.
  task automatic run_session(int unsigned pats, int unsigned maxlen, int unsigned text_len);
    send_req(REQ_CLEAR, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    for (int unsigned p = 0; p < pats; p++) insert_pattern($urandom_range(1, maxlen));
    send_req(REQ_BUILD, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    for (int unsigned t = 0; t < text_len; t++) begin
      case ($urandom_range(0, 39))
        0:       send_req(REQ_RESTART, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        1:       send_req(3'($urandom_range(5, 7)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
        2:       send_req(REQ_INSERT, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        3:       send_req(REQ_BUILD, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        default: send_req(REQ_SCAN, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  always @(posedge clk_i) if (req_if.valid && req_if.ready) sent <= sent + 1;

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_CLEAR;
    req_if.symbol   = 2'd0;
    req_if.last     = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: every request kind, refusals, both flag values, all symbols.
    send_req(REQ_RESTART, 2'd3, 1'b1);
    send_req(3'd7, 2'd2, 1'b0);
    send_req(REQ_CLEAR, 2'd0, 1'b0);
    send_req(REQ_SCAN, 2'd1, 1'b1);
    send_req(REQ_INSERT, 2'd0, 1'b0);
    send_req(REQ_INSERT, 2'd1, 1'b1);
    send_req(REQ_INSERT, 2'd1, 1'b0);
    send_req(REQ_INSERT, 2'd2, 1'b0);
    send_req(REQ_INSERT, 2'd3, 1'b1);
    send_req(REQ_INSERT, 2'd1, 1'b1);
    send_req(REQ_BUILD, 2'd0, 1'b0);
    send_req(REQ_BUILD, 2'd0, 1'b0);
    send_req(REQ_INSERT, 2'd2, 1'b1);
    for (int s = 0; s < 4; s++) send_req(REQ_SCAN, 2'(s), 1'b0);
    send_req(REQ_SCAN, 2'd0, 1'b0);
    send_req(REQ_SCAN, 2'd1, 1'b0);
    send_req(REQ_RESTART, 2'd0, 1'b0);
    send_req(3'd5, 2'd0, 1'b1);
    send_req(3'd6, 2'd3, 1'b0);
    // Long patterns until the node table overflows, then a full build.
    send_req(REQ_CLEAR, 2'd0, 1'b0);
    for (int p = 0; p < 24; p++) insert_pattern($urandom_range(6, 10));
    send_req(REQ_BUILD, 2'd0, 1'b0);
    long_stall = 1;
    for (int t = 0; t < 60; t++) send_req(REQ_SCAN, 2'($urandom_range(0, 3)), 1'b0);
    long_stall = 0;
    // Random sessions, mostly small tries.
    while (sent < 1650) begin
      if ($urandom_range(0, 9) == 0) run_session($urandom_range(10, 30), 8, 60);
      else run_session($urandom_range(1, 6), 5, $urandom_range(10, 40));
    end
    req_if.valid <= 1'b0;
    stim_done = 1;
  end

  // Result side: random stalls, plus one long hold-off during the overflow scan.
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        rsp_if.ready <= 1'b0;
        repeat (200) @(negedge clk_i);
        rsp_if.ready <= 1'b1;
        wait (!long_stall);
      end else begin
        gap = gap_len();
        if (gap == 0) rsp_if.ready <= 1'b1;
        else begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
